// ===== hdl/rlm_pkg.sv =====
// Package for the repetition latency monitor: run and event codes, the beat
// structures passed between stages, and the stream field widths.
// No dependencies.
package rlm_pkg;

    localparam int TS_W    = 64;
    localparam int BYTES_W = 32;
    localparam int CNT_W   = 32;
    localparam int MODE_W  = 3;
    localparam int RUN_W   = 2;

    localparam logic [RUN_W-1:0] RUN_UNINIT    = 2'd0;
    localparam logic [RUN_W-1:0] RUN_TESTING   = 2'd1;
    localparam logic [RUN_W-1:0] RUN_COMPLETED = 2'd2;
    localparam logic [RUN_W-1:0] RUN_ERROR     = 2'd3;

    localparam logic [MODE_W-1:0] EV_BEGIN = 3'd0;
    localparam logic [MODE_W-1:0] EV_END   = 3'd1;
    localparam logic [MODE_W-1:0] EV_BYTES = 3'd2;
    localparam logic [MODE_W-1:0] EV_CHECK = 3'd3;
    localparam logic [MODE_W-1:0] EV_WAVE  = 3'd4;

    localparam logic CFG_TARGET_BYTES = 1'b0;
    localparam logic CFG_TRY_TICKS    = 1'b1;

    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 232;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [TS_W-1:0]    timestamp;
        logic [BYTES_W-1:0] byte_count;
    } rlm_event_t;

    typedef struct packed {
        logic [RUN_W-1:0] state_code;
        logic             still_testing;
        logic [CNT_W-1:0] trial_count;
        logic [TS_W-1:0]  total_ticks;
        logic [TS_W-1:0]  min_ticks;
        logic [TS_W-1:0]  max_ticks;
        logic             new_minimum;
        logic             unbalanced_flag;
        logic             byte_mismatch_flag;
    } rlm_result_t;

endpackage

// ===== hdl/rlm_in_reg.sv =====
// Input register of the repetition latency monitor: holds one event beat
// until the update stage takes it. Depends on rlm_pkg.
module rlm_in_reg
    import rlm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  rlm_event_t in_event,
    output logic       out_valid,
    input  logic       out_ready,
    output rlm_event_t out_event
);

    logic       valid_reg;
    rlm_event_t event_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_event = event_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            event_reg <= in_event;
        end
    end

endmodule

// ===== hdl/rlm_core.sv =====
// Trial state and statistics of the repetition latency monitor, with the
// configuration registers and the combinational event update. Depends on rlm_pkg.
module rlm_core
    import rlm_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_write,
    input  logic             cfg_sel,
    input  logic [TS_W-1:0]  cfg_value,
    input  logic             step,
    input  rlm_event_t       ev,
    output rlm_result_t      result
);

    logic [TS_W-1:0]  target_bytes_reg;
    logic [TS_W-1:0]  try_ticks_reg;

    logic [RUN_W-1:0] run_mode_reg,     run_mode_next;
    logic [CNT_W-1:0] open_count_reg,   open_count_next;
    logic [CNT_W-1:0] close_count_reg,  close_count_next;
    logic [TS_W-1:0]  trial_time_reg,   trial_time_next;
    logic [TS_W-1:0]  trial_bytes_reg,  trial_bytes_next;
    logic [TS_W-1:0]  window_start_reg, window_start_next;
    logic [CNT_W-1:0] trials_reg,       trials_next;
    logic [TS_W-1:0]  time_sum_reg,     time_sum_next;
    logic [TS_W-1:0]  time_min_reg,     time_min_next;
    logic [TS_W-1:0]  time_max_reg,     time_max_next;

    logic             fresh_min;
    logic             unbalanced;
    logic             mismatch;
    logic [TS_W-1:0]  elapsed;

    assign elapsed = ev.timestamp - window_start_reg;

    always_comb begin
        run_mode_next     = run_mode_reg;
        open_count_next   = open_count_reg;
        close_count_next  = close_count_reg;
        trial_time_next   = trial_time_reg;
        trial_bytes_next  = trial_bytes_reg;
        window_start_next = window_start_reg;
        trials_next       = trials_reg;
        time_sum_next     = time_sum_reg;
        time_min_next     = time_min_reg;
        time_max_next     = time_max_reg;
        fresh_min         = 1'b0;
        unbalanced        = 1'b0;
        mismatch          = 1'b0;
        case (ev.mode)
            EV_BEGIN: begin
                open_count_next = open_count_reg + CNT_W'(1);
                trial_time_next = trial_time_reg - ev.timestamp;
            end
            EV_END: begin
                close_count_next = close_count_reg + CNT_W'(1);
                trial_time_next  = trial_time_reg + ev.timestamp;
            end
            EV_BYTES: begin
                trial_bytes_next = trial_bytes_reg + {{(TS_W-BYTES_W){1'b0}}, ev.byte_count};
            end
            EV_WAVE: begin
                if (run_mode_reg == RUN_UNINIT) begin
                    run_mode_next = RUN_TESTING;
                    time_min_next = '1;
                end else if (run_mode_reg == RUN_COMPLETED) begin
                    run_mode_next = RUN_TESTING;
                end
                window_start_next = ev.timestamp;
            end
            EV_CHECK: begin
                if (run_mode_reg == RUN_TESTING) begin
                    if (open_count_reg != '0) begin
                        unbalanced = (open_count_reg != close_count_reg);
                        mismatch   = (trial_bytes_reg != target_bytes_reg);
                        if (unbalanced || mismatch) begin
                            run_mode_next = RUN_ERROR;
                        end else begin
                            trials_next   = trials_reg + CNT_W'(1);
                            time_sum_next = time_sum_reg + trial_time_reg;
                            if (time_max_reg < trial_time_reg) begin
                                time_max_next = trial_time_reg;
                            end
                            if (time_min_reg > trial_time_reg) begin
                                time_min_next     = trial_time_reg;
                                window_start_next = ev.timestamp;
                                fresh_min         = 1'b1;
                            end
                            open_count_next  = '0;
                            close_count_next = '0;
                            trial_time_next  = '0;
                            trial_bytes_next = '0;
                        end
                    end
                    // a new minimum restarts the window, so the timeout check is skipped then
                    if (!fresh_min && (elapsed > try_ticks_reg)) begin
                        run_mode_next = RUN_COMPLETED;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        result.state_code         = run_mode_next;
        result.still_testing      = (run_mode_next == RUN_TESTING);
        result.trial_count        = trials_next;
        result.total_ticks        = time_sum_next;
        result.min_ticks          = time_min_next;
        result.max_ticks          = time_max_next;
        result.new_minimum        = fresh_min;
        result.unbalanced_flag    = unbalanced;
        result.byte_mismatch_flag = mismatch;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_bytes_reg <= '0;
            try_ticks_reg    <= '0;
        end else if (cfg_write) begin
            if (cfg_sel == CFG_TARGET_BYTES) begin
                target_bytes_reg <= cfg_value;
            end
            if (cfg_sel == CFG_TRY_TICKS) begin
                try_ticks_reg <= cfg_value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_mode_reg     <= RUN_UNINIT;
            open_count_reg   <= '0;
            close_count_reg  <= '0;
            trial_time_reg   <= '0;
            trial_bytes_reg  <= '0;
            window_start_reg <= '0;
            trials_reg       <= '0;
            time_sum_reg     <= '0;
            time_min_reg     <= '0;
            time_max_reg     <= '0;
        end else if (step) begin
            run_mode_reg     <= run_mode_next;
            open_count_reg   <= open_count_next;
            close_count_reg  <= close_count_next;
            trial_time_reg   <= trial_time_next;
            trial_bytes_reg  <= trial_bytes_next;
            window_start_reg <= window_start_next;
            trials_reg       <= trials_next;
            time_sum_reg     <= time_sum_next;
            time_min_reg     <= time_min_next;
            time_max_reg     <= time_max_next;
        end
    end

endmodule

// ===== hdl/repetition_latency_monitor.sv =====
// Top level of the repetition latency monitor: stream ports, input register,
// update core and result register. Depends on rlm_pkg, rlm_in_reg, rlm_core.
//
// One result beat per event beat, one beat per clock while m_tready stays high.
// An event passes the input register, then updates the trial state and is
// captured in the result register at the same clock edge. Throughput is
// limited only by the combinational state update of rlm_core (64-bit adds
// and compares), and stalls on m_tready back up to s_tready through the
// two register stages. Configuration writes are always accepted (cfg_ready
// is high) and must be made while no event is in flight.
module repetition_latency_monitor
    import rlm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // timestamp[63:0], byte_count[95:64]
    input  logic [MODE_W-1:0]    s_tuser,   // mode[2:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // state_code[1:0], still_testing[2], trial_count[34:3], total_ticks[98:35],
    // min_ticks[162:99], max_ticks[226:163], new_minimum[227],
    // unbalanced_flag[228], byte_mismatch_flag[229], zero[231:230]
    output logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [TS_W-1:0]      cfg_data
);

    rlm_event_t  in_event;
    rlm_event_t  held_event;
    rlm_result_t result;
    rlm_result_t result_reg;
    logic        held_valid;
    logic        out_valid_reg;
    logic        advance;

    assign in_event.mode       = s_tuser;
    assign in_event.timestamp  = s_tdata[TS_W-1:0];
    assign in_event.byte_count = s_tdata[TS_W+BYTES_W-1:TS_W];

    assign advance   = held_valid && (!out_valid_reg || m_tready);
    assign cfg_ready = 1'b1;

    rlm_in_reg u_in_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_event  (in_event),
        .out_valid (held_valid),
        .out_ready (!out_valid_reg || m_tready),
        .out_event (held_event)
    );

    rlm_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_write (cfg_valid),
        .cfg_sel   (cfg_index),
        .cfg_value (cfg_data),
        .step      (advance),
        .ev        (held_event),
        .result    (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg <= held_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00,
                       result_reg.byte_mismatch_flag,
                       result_reg.unbalanced_flag,
                       result_reg.new_minimum,
                       result_reg.max_ticks,
                       result_reg.min_ticks,
                       result_reg.total_ticks,
                       result_reg.trial_count,
                       result_reg.still_testing,
                       result_reg.state_code};

endmodule

// ===== dv/rlm_checker.sv =====
// Scoreboard for the repetition latency monitor: watches the event, result and
// register write channels, models the trial statistics and checks every result beat.
// Depends on rlm_pkg.
module rlm_checker
    import rlm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // timestamp[63:0], byte_count[95:64]
    input  logic [MODE_W-1:0]    s_tuser,   // mode[2:0]
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    // state_code[1:0], still_testing[2], trial_count[34:3], total_ticks[98:35],
    // min_ticks[162:99], max_ticks[226:163], new_minimum[227],
    // unbalanced_flag[228], byte_mismatch_flag[229], zero[231:230]
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [TS_W-1:0]      cfg_data,
    output int                   fail_count,
    output int                   results_in_flight,
    output logic [RUN_W-1:0]     modeled_run
);

    logic [TS_W-1:0]  byte_goal;
    logic [TS_W-1:0]  patience;
    logic [RUN_W-1:0] run_state;
    logic [CNT_W-1:0] opens;
    logic [CNT_W-1:0] closes;
    logic [TS_W-1:0]  trial_ticks;
    logic [TS_W-1:0]  trial_byte_sum;
    logic [TS_W-1:0]  window_origin;
    logic [CNT_W-1:0] trials_accepted;
    logic [TS_W-1:0]  tick_sum;
    logic [TS_W-1:0]  tick_min;
    logic [TS_W-1:0]  tick_max;
    rlm_result_t      expected_reports[$];

    initial fail_count = 0;

    task automatic clear_model();
        byte_goal       = '0;
        patience        = '0;
        run_state       = RUN_UNINIT;
        opens           = '0;
        closes          = '0;
        trial_ticks     = '0;
        trial_byte_sum  = '0;
        window_origin   = '0;
        trials_accepted = '0;
        tick_sum        = '0;
        tick_min        = '0;
        tick_max        = '0;
        expected_reports.delete();
    endtask

    task automatic fold_event(input logic [MODE_W-1:0] kind, input logic [TS_W-1:0] stamp,
                              input logic [BYTES_W-1:0] amount, output rlm_result_t report);
        report = '0;
        case (kind)
            EV_BEGIN: begin
                opens       = opens + 1'b1;
                trial_ticks = trial_ticks - stamp;
            end
            EV_END: begin
                closes      = closes + 1'b1;
                trial_ticks = trial_ticks + stamp;
            end
            EV_BYTES: begin
                trial_byte_sum = trial_byte_sum + TS_W'(amount);
            end
            EV_WAVE: begin
                if (run_state == RUN_UNINIT) begin
                    run_state = RUN_TESTING;
                    tick_min  = '1;
                end else if (run_state == RUN_COMPLETED) begin
                    run_state = RUN_TESTING;
                end
                window_origin = stamp;
            end
            EV_CHECK: begin
                if (run_state == RUN_TESTING) begin
                    if (opens != 0) begin
                        report.unbalanced_flag    = (opens != closes);
                        report.byte_mismatch_flag = (trial_byte_sum != byte_goal);
                        if (report.unbalanced_flag || report.byte_mismatch_flag) begin
                            run_state = RUN_ERROR;
                        end else begin
                            trials_accepted = trials_accepted + 1'b1;
                            tick_sum        = tick_sum + trial_ticks;
                            if (tick_max < trial_ticks) begin
                                tick_max = trial_ticks;
                            end
                            if (tick_min > trial_ticks) begin
                                tick_min           = trial_ticks;
                                window_origin      = stamp;
                                report.new_minimum = 1'b1;
                            end
                            opens          = '0;
                            closes         = '0;
                            trial_ticks    = '0;
                            trial_byte_sum = '0;
                        end
                    end
                    if (stamp - window_origin > patience) begin
                        run_state = RUN_COMPLETED;
                    end
                end
            end
            default: ;
        endcase
        report.state_code    = run_state;
        report.still_testing = (run_state == RUN_TESTING);
        report.trial_count   = trials_accepted;
        report.total_ticks   = tick_sum;
        report.min_ticks     = tick_min;
        report.max_ticks     = tick_max;
    endtask

    task automatic check_field(input string label, input logic [TS_W-1:0] want,
                               input logic [TS_W-1:0] seen);
        if (seen !== want) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, seen);
        end
    endtask

    always @(posedge aclk) begin
        rlm_result_t want;
        if (!aresetn) begin
            clear_model();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_reports.size() == 0) begin
                    fail_count++;
                    $display("%0t: result beat with none expected, expected nothing, actual %0h",
                             $time, m_tdata);
                end else begin
                    want = expected_reports.pop_front();
                    check_field("state_code", want.state_code, m_tdata[1:0]);
                    check_field("still_testing", want.still_testing, m_tdata[2]);
                    check_field("trial_count", want.trial_count, m_tdata[34:3]);
                    check_field("total_ticks", want.total_ticks, m_tdata[98:35]);
                    check_field("min_ticks", want.min_ticks, m_tdata[162:99]);
                    check_field("max_ticks", want.max_ticks, m_tdata[226:163]);
                    check_field("new_minimum", want.new_minimum, m_tdata[227]);
                    check_field("unbalanced_flag", want.unbalanced_flag, m_tdata[228]);
                    check_field("byte_mismatch_flag", want.byte_mismatch_flag, m_tdata[229]);
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_TARGET_BYTES) begin
                    byte_goal = cfg_data;
                end else begin
                    patience = cfg_data;
                end
            end
            if (s_tvalid && s_tready) begin
                fold_event(s_tuser, s_tdata[TS_W-1:0], s_tdata[S_TDATA_W-1:TS_W], want);
                expected_reports.push_back(want);
            end
        end
        results_in_flight = expected_reports.size();
        modeled_run       = run_state;
    end

endmodule

// ===== dv/repetition_latency_monitor_tb.sv =====
// Testbench top for the repetition latency monitor: clock, reset, event and
// register stimulus, receiver back-pressure and the final verdict.
// Depends on rlm_pkg, rlm_checker and repetition_latency_monitor.
module repetition_latency_monitor_tb;
    import rlm_pkg::*;

    localparam int RX_HOLD_CYCLES = 150;
    localparam int RANDOM_ITEMS   = 560;
    localparam int PHASES         = 6;

    localparam logic [MODE_W-1:0] EV_RSVD_A = 3'd5;
    localparam logic [MODE_W-1:0] EV_RSVD_B = 3'd6;
    localparam logic [MODE_W-1:0] EV_RSVD_C = 3'd7;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;   // timestamp[63:0], byte_count[95:64]
    logic [MODE_W-1:0]    s_tuser   = '0;   // mode[2:0]
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // see rlm_checker for the field map
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic                 cfg_index = 1'b0;
    logic [TS_W-1:0]      cfg_data  = '0;

    int               fail_count;
    int               results_in_flight;
    logic [RUN_W-1:0] modeled_run;

    bit              tx_burst    = 1'b0;
    bit              rx_burst    = 1'b0;
    bit              rx_hold_req = 1'b0;
    int              events_sent = 0;
    logic [TS_W-1:0] stamp       = '0;
    logic [TS_W-1:0] byte_goal   = '0;

    repetition_latency_monitor dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rlm_checker monitor_check (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .s_tuser           (s_tuser),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .fail_count        (fail_count),
        .results_in_flight (results_in_flight),
        .modeled_run       (modeled_run)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #4000000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int pick_gap(input bit burst);
        return burst ? 0 : int'($urandom_range(0, 11));
    endfunction

    function automatic logic [TS_W-1:0] tick_step();
        case ($urandom_range(0, 39))
            0: return {$urandom, $urandom};
            1: return '0;
            default: return TS_W'($urandom_range(1, 40));
        endcase
    endfunction

    // Keep tvalid high across back-to-back beats; drop it only for a gap.
    task automatic send_event(input logic [MODE_W-1:0] kind, input logic [TS_W-1:0] ts,
                              input logic [BYTES_W-1:0] amount);
        int gap;
        gap = pick_gap(tx_burst);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {amount, ts};
        do @(posedge aclk); while (!s_tready);
        if (kind <= EV_WAVE) begin
            events_sent++;
        end
    endtask

    task automatic emit(input logic [MODE_W-1:0] kind, input logic [TS_W-1:0] step,
                        input logic [BYTES_W-1:0] amount);
        stamp = stamp + step;
        send_event(kind, stamp, amount);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (results_in_flight != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [TS_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic set_config(input logic [TS_W-1:0] goal, input logic [TS_W-1:0] patience);
        drain();
        write_reg(CFG_TARGET_BYTES, goal);
        write_reg(CFG_TRY_TICKS, patience);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        byte_goal = goal;
    endtask

    // One well-formed trial: begin/end pairs, bytes adding up to the goal, then a check.
    task automatic run_trial();
        int                 pairs;
        bit                 nested;
        logic [TS_W-1:0]    left;
        logic [BYTES_W-1:0] chunk;
        logic [BYTES_W-1:0] chunks[$];
        pairs  = $urandom_range(1, 3);
        nested = $urandom_range(0, 1);
        left   = byte_goal;
        while (left != 0) begin
            if (left > 64'hFFFF_FFFF) begin
                chunk = ($urandom_range(0, 3) == 0) ? '1 : $urandom;
            end else if (left > 1 && $urandom_range(0, 2) == 0) begin
                chunk = $urandom_range(1, left[BYTES_W-1:0] - 1);
            end else begin
                chunk = left[BYTES_W-1:0];
            end
            if (chunk == 0) begin
                chunk = '1;
            end
            chunks.push_back(chunk);
            left = left - chunk;
        end
        if ($urandom_range(0, 4) == 0) begin
            chunks.push_back('0);
        end
        if (nested) begin
            repeat (pairs) emit(EV_BEGIN, tick_step(), $urandom);
            foreach (chunks[k]) emit(EV_BYTES, tick_step(), chunks[k]);
            repeat (pairs) emit(EV_END, tick_step(), $urandom);
        end else begin
            for (int i = 0; i < pairs; i++) begin
                emit(EV_BEGIN, tick_step(), $urandom);
                if (i == 0) begin
                    foreach (chunks[k]) emit(EV_BYTES, tick_step(), chunks[k]);
                end
                emit(EV_END, tick_step(), $urandom);
            end
        end
        // run mode moves only on check and wave beats, so it has long settled here
        if (modeled_run != RUN_TESTING) begin
            emit(EV_WAVE, tick_step(), $urandom);
        end
        emit(EV_CHECK, tick_step(), $urandom);
    endtask

    task automatic run_noise();
        case ($urandom_range(0, 2))
            0: send_event(EV_RSVD_A + 3'($urandom_range(0, 2)), {$urandom, $urandom}, $urandom);
            1: emit(EV_CHECK, tick_step(), $urandom);
            default: emit(EV_WAVE, tick_step(), $urandom);
        endcase
    endtask

    initial begin : receiver
        int wait_cycles;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            wait_cycles = pick_gap(rx_burst);
            if (rx_hold_req) begin
                wait_cycles = wait_cycles + RX_HOLD_CYCLES;
                rx_hold_req = 1'b0;
            end
            if (wait_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (wait_cycles) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin : stimulus
        logic [TS_W-1:0] goals[PHASES];
        logic [TS_W-1:0] waits[PHASES];
        int              base;
        goals[0] = '0;
        waits[0] = '0;
        goals[1] = 64'h1_0000_0000;
        waits[1] = 64'd300;
        goals[2] = 64'($urandom) + 64'($urandom) + 64'($urandom);
        waits[2] = 64'($urandom_range(100, 3000));
        goals[3] = 64'($urandom);
        waits[3] = '1;
        goals[4] = 64'($urandom_range(0, 5000));
        waits[4] = {$urandom, $urandom};
        goals[5] = 64'd12345;
        waits[5] = 64'd500;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        set_config(64'h1_0000_0000, 64'd1000);
        send_event(EV_RSVD_A, '1, '1);
        send_event(EV_RSVD_C, '0, '0);
        send_event(EV_CHECK, '0, '1);
        send_event(EV_WAVE, 64'd100, '0);
        send_event(EV_BEGIN, 64'hFFFF_FFFF_FFFF_FFF0, '0);
        send_event(EV_BYTES, 64'd110, '1);
        send_event(EV_BYTES, 64'd120, 32'd1);
        send_event(EV_BYTES, 64'd130, '0);
        send_event(EV_END, 64'h10, '1);
        send_event(EV_CHECK, 64'd200, '0);
        send_event(EV_BEGIN, 64'd300, '0);
        send_event(EV_BEGIN, 64'd310, '0);
        send_event(EV_BYTES, 64'd315, '1);
        send_event(EV_END, 64'd320, '0);
        send_event(EV_BYTES, 64'd325, 32'd1);
        send_event(EV_END, 64'd330, '0);
        send_event(EV_CHECK, 64'd400, '0);
        send_event(EV_CHECK, 64'd1201, '0);
        send_event(EV_BEGIN, 64'd1300, '0);
        send_event(EV_END, 64'd1305, '0);
        send_event(EV_RSVD_B, 64'd1310, '0);
        send_event(EV_WAVE, 64'd1400, '0);
        send_event(EV_BYTES, 64'd1410, '1);
        send_event(EV_BYTES, 64'd1420, 32'd1);
        send_event(EV_CHECK, 64'd1500, '0);
        stamp = 64'd1500;
        base  = events_sent;

        for (int p = 0; p < PHASES; p++) begin
            set_config(goals[p], waits[p]);
            tx_burst = (p == 1) || ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            if (p == 1) begin
                rx_hold_req = 1'b1;
            end
            while (events_sent < base + (p + 1) * RANDOM_ITEMS / PHASES) begin
                if ($urandom_range(0, 3) == 0) begin
                    run_noise();
                end
                run_trial();
                if ($urandom_range(0, 9) == 0) begin
                    tx_burst = !tx_burst;
                end
                if ($urandom_range(0, 9) == 0) begin
                    rx_burst = !rx_burst;
                end
            end
        end

        // faulty trials: byte mismatch past the window, then an unbalanced one
        tx_burst = 1'b0;
        rx_burst = 1'b0;
        set_config('1, 64'd50);
        emit(EV_WAVE, 64'd1, $urandom);
        emit(EV_BEGIN, 64'd5, $urandom);
        emit(EV_BYTES, 64'd1, 32'd5);
        emit(EV_END, 64'd5, $urandom);
        emit(EV_CHECK, 64'd100, $urandom);
        emit(EV_WAVE, 64'd1, $urandom);
        emit(EV_BEGIN, 64'd1, $urandom);
        emit(EV_CHECK, 64'd1, $urandom);
        emit(EV_WAVE, 64'd1, $urandom);
        emit(EV_CHECK, 64'd1, $urandom);
        emit(EV_END, 64'd1, $urandom);
        emit(EV_BYTES, 64'd1, '1);
        repeat (60) send_event(3'($urandom_range(0, 7)), {$urandom, $urandom}, $urandom);

        drain();
        repeat (8) @(negedge aclk);
        if (fail_count == 0 && results_in_flight == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
